// ===== rtl/seiudf_pkg.sv =====
// Shared types and constants for the SEI user data finder.
`default_nettype none

package seiudf_pkg;

  localparam logic [7:0]  NAL_TYPE_MASK   = 8'h1F;
  localparam logic [7:0]  SEI_NAL_TYPE    = 8'd6;
  localparam logic [15:0] USER_DATA_UNREG = 16'd5;
  localparam logic [7:0]  BYTE_ALL_ONES   = 8'd255;
  localparam int          MARK_OFFSET     = 16;
  localparam logic [7:0]  MARK_CHAR_V     = 8'h76;
  localparam logic [7:0]  MARK_CHAR_P     = 8'h70;
  localparam logic [7:0]  MARK_CHAR_U     = 8'h5F;

  typedef enum logic [2:0] {
    RD_POS,
    RD_POS1,
    RD_POS16,
    RD_J,
    RD_M1,
    RD_M2
  } rd_sel_t;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_FC_END,
    POS_FC_HIT,
    POS_INC,
    POS_LIM,
    POS_ADV
  } pos_src_t;

  typedef enum logic [1:0] {
    LIM_HOLD,
    LIM_FC_END,
    LIM_FC_HIT
  } lim_src_t;

  typedef struct packed {
    logic     in_ready;
    logic     fc_init;
    logic     fc_from_pos1;
    logic     fc_shift;
    logic     hold_byte;
    rd_sel_t  rd_sel;
    pos_src_t pos_src;
    lim_src_t lim_src;
    logic     clr_sums;
    logic     add_type;
    logic     add_size;
    logic     set_mark;
    logic     set_found;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic fc_range_end;
    logic fc_hit;
    logic pos_ge_n;
    logic pos1_ge_n;
    logic rd_zero;
    logic hdr_sei;
    logic ps_room;
    logic pair_zero;
    logic pos_ge_lim;
    logic rd_ff;
    logic size_bad;
    logic type_user;
    logic mark_ok;
    logic rd_is_v;
    logic rd_is_p;
    logic rd_is_u;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/h264_sei_user_data_finder.sv =====
// Top level of the H.264 Annex B SEI user data finder.
//
//   channel  dir  tdata bits (low first)                              tlast
//   s_axis   in   [7:0] data_byte                                     last_byte
//   m_axis   out  [0] found, [12:1] match_offset, [13] overflow, pad  -
//
// Bytes load at one per cycle into the packet memory while no scan is running; the transfer
// with tlast starts the scan, which does one registered memory read per step.
// Reset is synchronous; it clears control state only, the packet memory is never cleared.
// The result sits in an output register, so the next packet loads while it waits;
// a finished scan holds until that register is free.
`default_nettype none

module h264_sei_user_data_finder
  import seiudf_pkg::*;
#(
  parameter int MAX_PACKET = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] found, [12:1] match_offset, [13] overflow
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  cmd_t cmd;
  sts_t sts;

  seiudf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  seiudf_dp #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/seiudf_dp.sv =====
// Datapath: packet memory, scan pointers, message sums and result register.
`default_nettype none

module seiudf_dp
  import seiudf_pkg::*;
#(
  parameter int MAX_PACKET = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] found, [12:1] match_offset, [13] overflow
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire cmd_t        cmd,
  output sts_t             sts
);

  localparam int AW = $clog2(MAX_PACKET);
  localparam int PW = AW + 2;
  localparam int SW = ((PW > 17) ? PW : 17) + 1;
  localparam int OW = (PW > 12) ? PW : 12;
  localparam logic [PW-1:0] MAXP  = PW'(MAX_PACKET);
  localparam logic [PW-1:0] MAXP1 = PW'(MAX_PACKET + 1);

  logic [7:0]    mem [MAX_PACKET];
  logic [7:0]    rdata_q;
  logic          rd_ok_q;
  logic [PW-1:0] rd_addr;
  logic [7:0]    d;

  logic [PW-1:0] count;
  logic [PW-1:0] n;
  logic          ovf;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [PW-1:0] lim;
  logic [PW-1:0] j;
  logic [PW-1:0] m;
  logic [7:0]    b1;
  logic [7:0]    b2;
  logic [7:0]    b3;
  logic [1:0]    hcnt;
  logic [15:0]   type_sum;
  logic [15:0]   size_sum;
  logic [16:0]   type_add;
  logic [16:0]   size_add;
  logic          res_found;
  logic [11:0]   res_off;
  logic [OW-1:0] m_ext;
  logic [PW-1:0] fc_hit_pos;

  logic          out_found;
  logic [11:0]   out_off;
  logic          out_ovf;
  logic          in_fire;

  assign in_fire       = s_axis_tvalid & cmd.in_ready;
  assign s_axis_tready = cmd.in_ready;
  assign d             = rd_ok_q ? rdata_q : 8'd0;
  assign type_add      = {1'b0, type_sum} + {9'd0, d};
  assign size_add      = {1'b0, size_sum} + {9'd0, d};
  assign m_ext         = OW'(m);
  assign fc_hit_pos    = (hcnt == 2'd3 && b3 == 8'd0) ? (j - PW'(3)) : (j - PW'(2));

  always_comb begin
    unique case (cmd.rd_sel)
      RD_POS:   rd_addr = pos;
      RD_POS1:  rd_addr = pos + PW'(1);
      RD_POS16: rd_addr = pos + PW'(MARK_OFFSET);
      RD_J:     rd_addr = j;
      RD_M1:    rd_addr = m + PW'(1);
      RD_M2:    rd_addr = m + PW'(2);
      default:  rd_addr = pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && count < MAXP) begin
      mem[count[AW-1:0]] <= s_axis_tdata;
    end
    rdata_q <= mem[rd_addr[AW-1:0]];
    rd_ok_q <= rd_addr < n;
  end

  always_comb begin
    unique case (cmd.pos_src)
      POS_HOLD:   pos_next = pos;
      POS_FC_END: pos_next = n;
      POS_FC_HIT: pos_next = fc_hit_pos;
      POS_INC:    pos_next = pos + PW'(1);
      POS_LIM:    pos_next = lim;
      POS_ADV:    pos_next = pos + PW'(size_sum);
      default:    pos_next = pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      n         <= '0;
      ovf       <= 1'b0;
      res_found <= 1'b0;
    end else begin
      if (in_fire) begin
        if (s_axis_tlast) begin
          count     <= '0;
          n         <= (count < MAXP) ? count + PW'(1) : MAXP;
          ovf       <= count >= MAXP;
          res_found <= 1'b0;
        end else if (count < MAXP) begin
          count <= count + PW'(1);
        end else begin
          count <= MAXP1;
        end
      end
      if (cmd.set_found) begin
        res_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    unique case (cmd.lim_src)
      LIM_HOLD:   lim <= lim;
      LIM_FC_END: lim <= n;
      LIM_FC_HIT: lim <= fc_hit_pos;
      default:    lim <= lim;
    endcase
    if (cmd.fc_init) begin
      j    <= cmd.fc_from_pos1 ? pos + PW'(1) : '0;
      hcnt <= 2'd0;
    end else if (cmd.fc_shift) begin
      j    <= j + PW'(1);
      hcnt <= (hcnt == 2'd3) ? 2'd3 : hcnt + 2'd1;
    end
    if (cmd.fc_shift) begin
      b3 <= b2;
      b2 <= b1;
      b1 <= d;
    end else if (cmd.hold_byte) begin
      b1 <= d;
    end
    if (cmd.clr_sums) begin
      type_sum <= '0;
      size_sum <= '0;
    end else begin
      if (cmd.add_type) begin
        type_sum <= type_add[16] ? 16'hFFFF : type_add[15:0];
      end
      if (cmd.add_size) begin
        size_sum <= size_add[16] ? 16'hFFFF : size_add[15:0];
      end
    end
    if (cmd.set_mark) begin
      m <= pos + PW'(MARK_OFFSET);
    end
    if (in_fire && s_axis_tlast) begin
      res_off <= '0;
    end else if (cmd.set_found) begin
      res_off <= m_ext[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found <= res_found;
      out_off   <= res_found ? res_off : 12'd0;
      out_ovf   <= ovf;
    end
  end

  assign m_axis_tdata = {2'b00, out_ovf, out_off, out_found};

  always_comb begin
    sts.in_fire      = in_fire;
    sts.in_last      = s_axis_tlast;
    sts.fc_range_end = (j + PW'(2)) > n;
    sts.fc_hit       = (d == 8'd1) && (b1 == 8'd0) && (b2 == 8'd0) && hcnt[1];
    sts.pos_ge_n     = pos >= n;
    sts.pos1_ge_n    = (pos + PW'(1)) >= n;
    sts.rd_zero      = d == 8'd0;
    sts.hdr_sei      = (d & NAL_TYPE_MASK) == SEI_NAL_TYPE;
    sts.ps_room      = lim > (pos + PW'(2));
    sts.pair_zero    = (b1 | d) == 8'd0;
    sts.pos_ge_lim   = pos >= lim;
    sts.rd_ff        = d == BYTE_ALL_ONES;
    sts.size_bad     = (SW'(pos) + SW'(size_sum)) > SW'(lim);
    sts.type_user    = type_sum == USER_DATA_UNREG;
    sts.mark_ok      = (pos + PW'(MARK_OFFSET + 2)) < n;
    sts.rd_is_v      = d == MARK_CHAR_V;
    sts.rd_is_p      = d == MARK_CHAR_P;
    sts.rd_is_u      = d == MARK_CHAR_U;
    sts.out_free     = !m_axis_tvalid || m_axis_tready;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAXP1)
    else $error("byte count beyond saturation value");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !s_axis_tlast && count < MAXP) |=> count == $past(count) + PW'(1))
    else $error("byte count did not advance on stored byte");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_axis_tvalid)
    else $error("result not presented after emit");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten while pending");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_found) |-> out_off == 12'd0)
    else $error("nonzero offset without match");
`endif

endmodule

`default_nettype wire

// ===== rtl/seiudf_ctrl.sv =====
// Controller: load and scan sequencer for the SEI user data finder.
`default_nettype none

module seiudf_ctrl
  import seiudf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [20:0] {
    S_LOAD    = 21'h000001,
    S_FA_RD   = 21'h000002,
    S_FA_CHK  = 21'h000004,
    S_SK_RD   = 21'h000008,
    S_SK_CHK  = 21'h000010,
    S_FB_RD   = 21'h000020,
    S_FB_CHK  = 21'h000040,
    S_HD_RD   = 21'h000080,
    S_HD_CHK  = 21'h000100,
    S_PS_TOP  = 21'h000200,
    S_PS_B0   = 21'h000400,
    S_PS_B1   = 21'h000800,
    S_TY_RD   = 21'h001000,
    S_TY_CHK  = 21'h002000,
    S_SZ_RD   = 21'h004000,
    S_SZ_CHK  = 21'h008000,
    S_SZ_TEST = 21'h010000,
    S_MK_V    = 21'h020000,
    S_MK_P    = 21'h040000,
    S_MK_U    = 21'h080000,
    S_FINISH  = 21'h100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel  = RD_POS;
    cmd.pos_src = POS_HOLD;
    cmd.lim_src = LIM_HOLD;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire && sts.in_last) begin
          cmd.fc_init = 1'b1;
          state_next  = S_FA_RD;
        end
      end
      S_FA_RD: begin
        if (sts.fc_range_end) begin
          cmd.pos_src = POS_FC_END;
          state_next  = S_SK_RD;
        end else begin
          cmd.rd_sel = RD_J;
          state_next = S_FA_CHK;
        end
      end
      S_FA_CHK: begin
        if (sts.fc_hit) begin
          cmd.pos_src = POS_FC_HIT;
          state_next  = S_SK_RD;
        end else begin
          cmd.fc_shift = 1'b1;
          state_next   = S_FA_RD;
        end
      end
      S_SK_RD: begin
        if (sts.pos_ge_n) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_sel = RD_POS;
          state_next = S_SK_CHK;
        end
      end
      S_SK_CHK: begin
        priority if (sts.rd_zero) begin
          cmd.pos_src = POS_INC;
          state_next  = S_SK_RD;
        end else if (sts.pos1_ge_n) begin
          state_next = S_FINISH;
        end else begin
          cmd.pos_src      = POS_INC;
          cmd.fc_init      = 1'b1;
          cmd.fc_from_pos1 = 1'b1;
          state_next       = S_FB_RD;
        end
      end
      S_FB_RD: begin
        if (sts.fc_range_end) begin
          cmd.lim_src = LIM_FC_END;
          state_next  = S_HD_RD;
        end else begin
          cmd.rd_sel = RD_J;
          state_next = S_FB_CHK;
        end
      end
      S_FB_CHK: begin
        if (sts.fc_hit) begin
          cmd.lim_src = LIM_FC_HIT;
          state_next  = S_HD_RD;
        end else begin
          cmd.fc_shift = 1'b1;
          state_next   = S_FB_RD;
        end
      end
      S_HD_RD: begin
        cmd.rd_sel = RD_POS;
        state_next = S_HD_CHK;
      end
      S_HD_CHK: begin
        if (sts.hdr_sei) begin
          cmd.pos_src = POS_INC;
          state_next  = S_PS_TOP;
        end else begin
          cmd.pos_src = POS_LIM;
          state_next  = S_SK_RD;
        end
      end
      S_PS_TOP: begin
        if (!sts.ps_room) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_sel = RD_POS;
          state_next = S_PS_B0;
        end
      end
      S_PS_B0: begin
        cmd.hold_byte = 1'b1;
        cmd.rd_sel    = RD_POS1;
        state_next    = S_PS_B1;
      end
      S_PS_B1: begin
        if (sts.pair_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.clr_sums = 1'b1;
          state_next   = S_TY_RD;
        end
      end
      S_TY_RD: begin
        if (sts.pos_ge_lim) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_sel = RD_POS;
          state_next = S_TY_CHK;
        end
      end
      S_TY_CHK: begin
        cmd.add_type = 1'b1;
        cmd.pos_src  = POS_INC;
        state_next   = sts.rd_ff ? S_TY_RD : S_SZ_RD;
      end
      S_SZ_RD: begin
        if (sts.pos_ge_lim) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_sel = RD_POS;
          state_next = S_SZ_CHK;
        end
      end
      S_SZ_CHK: begin
        cmd.add_size = 1'b1;
        cmd.pos_src  = POS_INC;
        state_next   = sts.rd_ff ? S_SZ_RD : S_SZ_TEST;
      end
      S_SZ_TEST: begin
        priority if (sts.size_bad) begin
          state_next = S_FINISH;
        end else if (sts.type_user && sts.mark_ok) begin
          cmd.set_mark = 1'b1;
          cmd.rd_sel   = RD_POS16;
          state_next   = S_MK_V;
        end else begin
          cmd.pos_src = POS_ADV;
          state_next  = S_PS_TOP;
        end
      end
      S_MK_V: begin
        if (sts.rd_is_v) begin
          cmd.rd_sel = RD_M1;
          state_next = S_MK_P;
        end else begin
          cmd.pos_src = POS_ADV;
          state_next  = S_PS_TOP;
        end
      end
      S_MK_P: begin
        if (sts.rd_is_p) begin
          cmd.rd_sel = RD_M2;
          state_next = S_MK_U;
        end else begin
          cmd.pos_src = POS_ADV;
          state_next  = S_PS_TOP;
        end
      end
      S_MK_U: begin
        if (sts.rd_is_u) begin
          cmd.set_found = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.pos_src = POS_ADV;
          state_next  = S_PS_TOP;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire
